FILE: rtl/core/idalloc_pkg.sv
// ----------------------------------------------------------------------------
// idalloc_pkg
// Shared types and codes for the identifier allocator with a free queue.
// ----------------------------------------------------------------------------
package idalloc_pkg;

	localparam int unsigned ID_W     = 8;
	localparam int unsigned MAP_MAX  = 256;
	localparam int unsigned STATUS_W = 2;

	typedef enum logic {
		REQ_ALLOC   = 1'b0,
		REQ_RELEASE = 1'b1
	} req_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK          = 2'd0,
		ST_BAD_RELEASE = 2'd1,
		ST_EXHAUSTED   = 2'd2
	} status_t;

	typedef struct packed {
		logic            push;
		logic            pop;
		logic [ID_W-1:0] data;
	} fq_ctrl_t;

	typedef struct packed {
		logic            empty;
		logic [ID_W-1:0] head;
	} fq_stat_t;

endpackage

FILE: rtl/core/idalloc_free_queue.sv
// ----------------------------------------------------------------------------
// idalloc_free_queue
// Circular queue of released identifiers with a registered head read and a
// write-to-head bypass, so the oldest entry is ready in every cycle.
// ----------------------------------------------------------------------------
module idalloc_free_queue import idalloc_pkg::*; #(
	parameter int unsigned DEPTH = 256
) (
	input  logic     clk,
	input  logic     arst_n,
	input  fq_ctrl_t ctrl,
	output fq_stat_t stat
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	logic [ID_W-1:0]  mem [DEPTH];
	logic [PTR_W-1:0] head_q;
	logic [PTR_W-1:0] tail_q;
	logic [CNT_W-1:0] count_q;
	logic [ID_W-1:0]  rd_q;
	logic             byp_q;
	logic [ID_W-1:0]  byp_data_q;

	logic             push_ok;
	logic [PTR_W-1:0] head_nxt;
	logic [PTR_W-1:0] tail_inc;
	logic [PTR_W-1:0] head_inc;

	assign push_ok  = ctrl.push && (count_q != CNT_W'(DEPTH));
	assign head_inc = (head_q == PTR_W'(DEPTH - 1)) ? '0 : head_q + 1'b1;
	assign tail_inc = (tail_q == PTR_W'(DEPTH - 1)) ? '0 : tail_q + 1'b1;
	assign head_nxt = ctrl.pop ? head_inc : head_q;

	assign stat.empty = (count_q == '0);
	assign stat.head  = byp_q ? byp_data_q : rd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			byp_q   <= 1'b0;
		end else begin
			head_q <= head_nxt;
			if (push_ok) begin
				tail_q <= tail_inc;
			end
			if (push_ok && !ctrl.pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push_ok && ctrl.pop) begin
				count_q <= count_q - 1'b1;
			end
			byp_q <= push_ok && (tail_q == head_nxt);
		end
	end

	always_ff @(posedge clk) begin
		if (push_ok) begin
			mem[tail_q] <= ctrl.data;
		end
		rd_q       <= mem[head_nxt];
		byp_data_q <= ctrl.data;
	end

endmodule

FILE: rtl/core/id_allocator_free_list_top.sv
// ----------------------------------------------------------------------------
// id_allocator_free_list_top
// Identifier allocator: allocate from a free queue, else from a high-water
// counter; release back into the queue after a check of the used bitmap.
// ----------------------------------------------------------------------------
// channel  dir  tdata                  tuser
// s_axis   in   [7:0] target_id        [0] req_type
// m_axis   out  [7:0] granted_id       [1:0] status
//
// One request per cycle while the result side accepts; a request that is taken
// loads the input register and then moves on into the result register, which
// drives m_axis.
// The bitmap, queue pointers and counters are cleared by reset at once;
// no clearing pass.
// A stalled result holds the result register and, behind it, the input
// register; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module id_allocator_free_list_top import idalloc_pkg::*; #(
	parameter int unsigned ID_COUNT = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [ID_W-1:0]     s_axis_tdata,  // [7:0] target_id
	input  logic                s_axis_tuser,  // [0] req_type
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [ID_W-1:0]     m_axis_tdata,  // [7:0] granted_id
	output logic [STATUS_W-1:0] m_axis_tuser   // [1:0] status
);

	localparam int unsigned MAP_DEPTH = (ID_COUNT < MAP_MAX) ? ID_COUNT : MAP_MAX;
	localparam int unsigned MAP_W     = $clog2(MAP_DEPTH);
	localparam int unsigned FRESH_W   = $clog2(ID_COUNT + 1);

	logic                 s1_valid_q;
	req_t                 req_s1;
	logic [ID_W-1:0]      target_s1;

	logic                 out_valid_q;
	logic [ID_W-1:0]      granted_s2;
	status_t              status_s2;

	logic [MAP_DEPTH-1:0] used_q;
	logic [FRESH_W-1:0]   fresh_q;

	fq_ctrl_t             fq_ctrl;
	fq_stat_t             fq_stat;

	logic                 fire;
	logic                 tgt_in_range;
	logic                 rel_hit;
	logic                 fresh_avail;
	logic                 fresh_mapped;
	logic                 take_fresh;
	logic                 set_en;
	logic [MAP_W-1:0]     set_idx;
	logic                 clr_en;
	logic [ID_W-1:0]      granted_d;
	status_t              status_d;

	assign fire          = s1_valid_q && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !s1_valid_q || fire;

	assign tgt_in_range = ({1'b0, target_s1} < (ID_W + 1)'(MAP_DEPTH));
	assign rel_hit      = tgt_in_range && used_q[target_s1[MAP_W-1:0]];
	assign fresh_avail  = (fresh_q != FRESH_W'(ID_COUNT));
	assign fresh_mapped = (fresh_q < FRESH_W'(MAP_DEPTH));

	always_comb begin
		fq_ctrl.push = 1'b0;
		fq_ctrl.pop  = 1'b0;
		fq_ctrl.data = target_s1;
		take_fresh   = 1'b0;
		set_en       = 1'b0;
		set_idx      = fq_stat.head[MAP_W-1:0];
		clr_en       = 1'b0;
		granted_d    = '0;
		status_d     = ST_OK;
		if (req_s1 == REQ_RELEASE) begin
			if (rel_hit) begin
				clr_en       = fire;
				fq_ctrl.push = fire;
			end else begin
				status_d = ST_BAD_RELEASE;
			end
		end else if (!fq_stat.empty) begin
			fq_ctrl.pop = fire;
			set_en      = fire;
			granted_d   = fq_stat.head;
		end else if (fresh_avail) begin
			take_fresh = fire;
			set_en     = fire && fresh_mapped;
			set_idx    = fresh_q[MAP_W-1:0];
			granted_d  = ID_W'(fresh_q);
		end else begin
			status_d = ST_EXHAUSTED;
		end
	end

	idalloc_free_queue #(
		.DEPTH(MAP_DEPTH)
	) u_free_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.ctrl  (fq_ctrl),
		.stat  (fq_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
			used_q      <= '0;
			fresh_q     <= '0;
		end else begin
			if (s_axis_tready) begin
				s1_valid_q <= s_axis_tvalid;
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			if (set_en) begin
				used_q[set_idx] <= 1'b1;
			end
			if (clr_en) begin
				used_q[target_s1[MAP_W-1:0]] <= 1'b0;
			end
			if (take_fresh) begin
				fresh_q <= fresh_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			req_s1    <= req_t'(s_axis_tuser);
			target_s1 <= s_axis_tdata;
		end
		if (fire) begin
			granted_s2 <= granted_d;
			status_s2  <= status_d;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = granted_s2;
	assign m_axis_tuser  = status_s2;

endmodule

FILE: tb/sv/idalloc_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idalloc_tb_pkg
// Scoreboard for the identifier allocator: mirrors the used bitmap, the queue
// of released identifiers and the high-water counter, predicts one result per
// accepted request and checks the results in order.
// ----------------------------------------------------------------------------
package idalloc_tb_pkg;

	import idalloc_pkg::*;

	localparam int unsigned IDS = 256;

	typedef struct packed {
		logic [ID_W-1:0] granted;
		status_t         status;
	} alloc_result_t;

	class alloc_scoreboard;

		bit              in_use [IDS];
		logic [ID_W-1:0] released_ids [$];
		int unsigned     next_fresh;
		alloc_result_t   expected_results [$];
		int unsigned     errors;
		int unsigned     n_requests;
		int unsigned     n_grants;
		int unsigned     n_releases;
		int unsigned     n_bad_releases;
		int unsigned     n_exhausted;

		function new();
			foreach (in_use[i]) in_use[i] = 1'b0;
			next_fresh     = 0;
			errors         = 0;
			n_requests     = 0;
			n_grants       = 0;
			n_releases     = 0;
			n_bad_releases = 0;
			n_exhausted    = 0;
		endfunction

		function int unsigned pending();
			return expected_results.size();
		endfunction

		// random identifier currently handed out, or any identifier if none is
		function logic [ID_W-1:0] pick_in_use();
			logic [ID_W-1:0] held [$];
			for (int i = 0; i < IDS; i++) begin
				if (in_use[i]) held.insert(held.size(), ID_W'(i));
			end
			if (held.size() == 0) return ID_W'($urandom_range(0, IDS - 1));
			return held[$urandom_range(0, held.size() - 1)];
		endfunction

		function void note_request(req_t kind, logic [ID_W-1:0] target);
			alloc_result_t res;
			int unsigned   id;
			res.granted = '0;
			res.status  = ST_OK;
			n_requests++;
			if (kind == REQ_ALLOC) begin
				if (released_ids.size() > 0) begin
					id = released_ids.pop_front();
				end else if (next_fresh < IDS) begin
					id = next_fresh;
					next_fresh++;
				end else begin
					id = IDS;
				end
				if (id < IDS) begin
					in_use[id]  = 1'b1;
					res.granted = ID_W'(id);
					n_grants++;
				end else begin
					res.status = ST_EXHAUSTED;
					n_exhausted++;
				end
			end else begin
				if (in_use[target]) begin
					in_use[target] = 1'b0;
					if (released_ids.size() < IDS)
						released_ids.insert(released_ids.size(), target);
					n_releases++;
				end else begin
					res.status = ST_BAD_RELEASE;
					n_bad_releases++;
				end
			end
			expected_results.insert(expected_results.size(), res);
		endfunction

		function void check_result(logic [ID_W-1:0] granted, logic [STATUS_W-1:0] status);
			alloc_result_t exp_res;
			if (expected_results.size() == 0) begin
				$error("result with no request outstanding: granted_id %0d, status %0d",
					granted, status);
				errors++;
				return;
			end
			exp_res = expected_results.pop_front();
			if (granted !== exp_res.granted) begin
				$error("granted_id: expected %0d, got %0d", exp_res.granted, granted);
				errors++;
			end
			if (status !== exp_res.status) begin
				$error("status: expected %0d, got %0d", exp_res.status, status);
				errors++;
			end
		endfunction

	endclass

endpackage

FILE: tb/sv/id_allocator_free_list_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// id_allocator_free_list_top_tb
// Drives allocate and release requests into the identifier allocator and
// checks every result against a scoreboard that mirrors the bitmap, the free
// queue and the high-water counter. A short directed run is followed by
// random runs that exhaust the identifier space, drain it again and mix both,
// with random idling on both streams and one long stall of the result side.
// ----------------------------------------------------------------------------
module id_allocator_free_list_top_tb;

	import idalloc_pkg::*;
	import idalloc_tb_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned LONG_HOLD   = 300;

	logic                clk;
	logic                arst_n;
	logic                s_axis_tvalid;
	logic                s_axis_tready;
	logic [ID_W-1:0]     s_axis_tdata;  // [7:0] target_id
	logic                s_axis_tuser;  // [0] req_type
	logic                m_axis_tvalid;
	logic                m_axis_tready;
	logic [ID_W-1:0]     m_axis_tdata;  // [7:0] granted_id
	logic [STATUS_W-1:0] m_axis_tuser;  // [1:0] status

	alloc_scoreboard sb;
	int unsigned     cycles;
	int unsigned     hold_cycles;
	bit              rx_idle_en;
	bit              tx_idle_en;

	id_allocator_free_list_top #(.ID_COUNT(IDS)) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
	end

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("DONE: errors detected");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready)
			sb.note_request(req_t'(s_axis_tuser), s_axis_tdata);
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata, m_axis_tuser);
	end

	// result side: random stall bursts, or one long hold-off when asked
	initial begin : result_side
		int unsigned stall_left;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (!arst_n) begin
				m_axis_tready <= 1'b0;
			end else if (hold_cycles > 0) begin
				m_axis_tready <= 1'b0;
				hold_cycles = hold_cycles - 1;
			end else if (stall_left > 0) begin
				m_axis_tready <= 1'b0;
				stall_left--;
			end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
				m_axis_tready <= 1'b0;
				stall_left = $urandom_range(0, 16);
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	task automatic issue(input req_t kind, input bit from_map, input logic [ID_W-1:0] id);
		logic [ID_W-1:0] target;
		@(negedge clk);
		target = from_map ? sb.pick_in_use() : id;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= target;
		s_axis_tuser  <= kind;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	task automatic tx_gap(input int unsigned n);
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= ID_W'($urandom);
		repeat (n) @(posedge clk);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
	endtask

	task automatic run_mix(input int unsigned n, input int unsigned pct_alloc,
		input int unsigned pct_map);
		int unsigned r;
		for (int unsigned i = 0; i < n; i++) begin
			if (tx_idle_en && $urandom_range(0, 7) == 0) tx_gap($urandom_range(1, 17));
			r = $urandom_range(0, 99);
			if (r < pct_alloc)
				issue(REQ_ALLOC, 1'b0, ID_W'($urandom));
			else if (r < pct_alloc + pct_map)
				issue(REQ_RELEASE, 1'b1, '0);
			else
				issue(REQ_RELEASE, 1'b0, ID_W'($urandom));
		end
	endtask

	initial begin
		sb            = new();
		cycles        = 0;
		hold_cycles   = 0;
		rx_idle_en    = 1'b1;
		tx_idle_en    = 1'b0;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = REQ_ALLOC;
		m_axis_tready = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// release before anything is handed out, then fresh grants
		issue(REQ_RELEASE, 1'b0, 8'd0);
		issue(REQ_RELEASE, 1'b0, 8'd255);
		issue(REQ_ALLOC,   1'b0, 8'd0);
		issue(REQ_ALLOC,   1'b0, 8'd0);
		issue(REQ_ALLOC,   1'b0, 8'd0);
		// double release, then reuse in release order
		issue(REQ_RELEASE, 1'b0, 8'd1);
		issue(REQ_RELEASE, 1'b0, 8'd1);
		issue(REQ_RELEASE, 1'b0, 8'd0);
		issue(REQ_ALLOC,   1'b0, 8'd255);
		issue(REQ_ALLOC,   1'b0, 8'd170);
		issue(REQ_ALLOC,   1'b0, 8'd85);
		issue(REQ_RELEASE, 1'b0, 8'd255);
		issue(REQ_RELEASE, 1'b0, 8'd2);
		issue(REQ_RELEASE, 1'b0, 8'd3);
		issue(REQ_RELEASE, 1'b0, 8'd2);
		issue(REQ_ALLOC,   1'b0, 8'd0);
		issue(REQ_ALLOC,   1'b0, 8'd0);
		issue(REQ_ALLOC,   1'b0, 8'd0);
		wait_drained();

		// fill up past exhaustion
		tx_idle_en = 1'b1;
		run_mix(400, 90, 7);
		wait_drained();

		// drain, starting under a long result-side hold-off
		hold_cycles = LONG_HOLD;
		run_mix(250, 25, 60);
		wait_drained();

		rx_idle_en = 1'b0;
		tx_idle_en = 1'b0;
		run_mix(200, 50, 35);
		wait_drained();
		repeat (10) @(posedge clk);

		$display("Covered %0d requests: %0d grants, %0d good releases,", sb.n_requests,
			sb.n_grants, sb.n_releases);
		$display("%0d rejected releases and %0d allocates with no identifier left.",
			sb.n_bad_releases, sb.n_exhausted);
		if (sb.errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

FILE: files.f
rtl/core/idalloc_pkg.sv
rtl/core/idalloc_free_queue.sv
rtl/core/id_allocator_free_list_top.sv
tb/sv/idalloc_tb_pkg.sv
tb/sv/id_allocator_free_list_top_tb.sv
